// ===== rtl/core/bmc4b5b_pkg.sv =====
// shared types, codes and symbol table of the bmc edge timing 4b5b receiver
package bmc4b5b_pkg;

    // line patterns seen in the 32-entry gap window while hunting
    localparam logic [31:0] PAT_SOP        = 32'hC7E3_C78D;
    localparam logic [31:0] PAT_HARD_RESET = 32'hF33F_3F3F;
    localparam logic [31:0] PAT_CABLE_RST  = 32'h3C7F_E0FF;

    // symbol table codes outside the nibble range
    localparam logic [7:0] CODE_ERR = 8'h90;
    localparam logic [7:0] CODE_EOP = 8'hF0;

    localparam logic [7:0] THRESH_RESET = 8'd60;
    localparam logic [7:0] COUNT_MAX    = 8'hFF;

    // result queue depth
    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);
    localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

    // 4b5b decode, first line bit in index bit 0
    localparam logic [7:0] SYM_TABLE [32] = '{
        CODE_ERR, CODE_ERR, CODE_ERR, CODE_ERR, CODE_ERR, CODE_ERR, CODE_ERR, CODE_ERR,
        CODE_ERR, 8'h01,    8'h04,    8'h05,    CODE_ERR, CODE_EOP, 8'h06,    8'h07,
        CODE_ERR, CODE_ERR, 8'h08,    8'h09,    8'h02,    8'h03,    8'h0A,    8'h0B,
        CODE_ERR, CODE_ERR, 8'h0C,    8'h0D,    8'h0E,    8'h0F,    8'h00,    CODE_ERR
    };

    typedef enum logic [1:0] {
        PH_HUNT   = 2'd0,
        PH_DECODE = 2'd1,
        PH_DONE   = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        KIND_DATA       = 3'd0,
        KIND_END        = 3'd1,
        KIND_HARD_RST   = 3'd2,
        KIND_CABLE_RST  = 3'd3,
        KIND_DEC_ERR    = 3'd4,
        KIND_UNFINISHED = 3'd5
    } t_kind;

    typedef struct packed {
        logic [7:0] edge_time;
        logic       capture_end;
    } t_edge_word;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data_byte;
        logic [7:0] byte_total;
        logic       done_res;
    } t_res_word;

    // results of one edge handed to the queue
    typedef struct packed {
        logic [1:0] count;
        t_res_word  res0;
        t_res_word  res1;
    } t_res_push;

endpackage

// ===== rtl/core/bmc4b5b_decode.sv =====
// edge gap classification, pattern hunt, bmc and 4b5b decode of one edge word
module bmc4b5b_decode (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [7:0]             i_cfg_thr,
    input  logic                   i_go,
    input  bmc4b5b_pkg::t_edge_word i_word,
    output bmc4b5b_pkg::t_res_push o_push
);

    logic [7:0]          r_thr;
    bmc4b5b_pkg::t_phase r_phase, n_phase;
    logic                r_ref_valid, n_ref_valid;
    logic [7:0]          r_prev, n_prev;
    logic [31:0]         r_window, n_window;
    logic                r_skip, n_skip;
    logic [2:0]          r_bitpos, n_bitpos;
    logic [4:0]          r_sym, n_sym;
    logic [4:0]          r_held, n_held;
    logic [7:0]          r_cnt, n_cnt;

    logic [7:0]          w_gap;
    logic                w_short;
    logic [31:0]         w_hunt_win;
    logic [4:0]          w_sym_new;
    logic                w_sym_done;
    logic [7:0]          w_code;
    logic                w_code_data;
    logic [7:0]          w_cnt_inc;
    bmc4b5b_pkg::t_phase w_step_phase;
    logic [7:0]          w_step_cnt;

    bmc4b5b_pkg::t_res_word w_ev, w_unf;
    logic                   w_ev_valid, w_unf_valid;

    // threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= bmc4b5b_pkg::THRESH_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_thr;
        end
    end

    // gap classification and symbol assembly
    assign w_gap       = i_word.edge_time - r_prev;
    assign w_short     = (w_gap < r_thr);
    assign w_hunt_win  = {w_short, r_window[31:1]};
    assign w_sym_new   = r_sym | (w_short ? (5'd1 << r_bitpos) : 5'd0);
    assign w_sym_done  = (r_bitpos == 3'd4);
    assign w_code      = bmc4b5b_pkg::SYM_TABLE[w_sym_new];
    assign w_code_data = (w_code[7:4] == 4'd0);
    assign w_cnt_inc   = (r_cnt == bmc4b5b_pkg::COUNT_MAX) ? r_cnt : r_cnt + 8'd1;

    // next state
    always_comb begin
        n_phase     = r_phase;
        n_ref_valid = r_ref_valid;
        n_prev      = r_prev;
        n_window    = r_window;
        n_skip      = r_skip;
        n_bitpos    = r_bitpos;
        n_sym       = r_sym;
        n_held      = r_held;
        n_cnt       = r_cnt;
        if (i_go) begin
            if (!r_ref_valid) begin
                n_ref_valid = 1'b1;
                n_prev      = i_word.edge_time;
            end else begin
                case (r_phase)
                    bmc4b5b_pkg::PH_HUNT: begin
                        n_prev   = i_word.edge_time;
                        n_window = w_hunt_win;
                        if (w_hunt_win == bmc4b5b_pkg::PAT_SOP) begin
                            n_phase  = bmc4b5b_pkg::PH_DECODE;
                            n_skip   = 1'b0;
                            n_bitpos = 3'd0;
                            n_sym    = 5'd0;
                            n_held   = 5'd0;
                            n_cnt    = 8'd0;
                        end else if (w_hunt_win == bmc4b5b_pkg::PAT_HARD_RESET ||
                                     w_hunt_win == bmc4b5b_pkg::PAT_CABLE_RST) begin
                            n_phase = bmc4b5b_pkg::PH_DONE;
                        end
                    end
                    bmc4b5b_pkg::PH_DECODE: begin
                        n_prev = i_word.edge_time;
                        if (r_skip) begin
                            n_skip = 1'b0;
                        end else begin
                            n_skip = w_short;
                            if (w_sym_done) begin
                                n_bitpos = 3'd0;
                                n_sym    = 5'd0;
                                if (!r_held[4]) begin
                                    if (w_code_data) begin
                                        n_held = {1'b1, w_code[3:0]};
                                    end else begin
                                        n_phase = bmc4b5b_pkg::PH_DONE;
                                    end
                                end else begin
                                    if (w_code_data) begin
                                        n_cnt = w_cnt_inc;
                                    end else begin
                                        n_phase = bmc4b5b_pkg::PH_DONE;
                                    end
                                    n_held = 5'd0;
                                end
                            end else begin
                                n_bitpos = r_bitpos + 3'd1;
                                n_sym    = w_sym_new;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
        w_step_phase = n_phase;
        w_step_cnt   = n_cnt;
        // rearm after the last edge of a capture
        if (i_go && i_word.capture_end) begin
            n_phase     = bmc4b5b_pkg::PH_HUNT;
            n_ref_valid = 1'b0;
            n_prev      = 8'd0;
            n_window    = 32'd0;
            n_skip      = 1'b0;
            n_bitpos    = 3'd0;
            n_sym       = 5'd0;
            n_held      = 5'd0;
            n_cnt       = 8'd0;
        end
    end

    // result words
    always_comb begin
        w_ev_valid = 1'b0;
        w_ev       = '0;
        if (i_go && r_ref_valid) begin
            case (r_phase)
                bmc4b5b_pkg::PH_HUNT: begin
                    if (w_hunt_win == bmc4b5b_pkg::PAT_HARD_RESET) begin
                        w_ev_valid  = 1'b1;
                        w_ev.kind   = bmc4b5b_pkg::KIND_HARD_RST;
                        w_ev.done_res = 1'b1;
                    end else if (w_hunt_win == bmc4b5b_pkg::PAT_CABLE_RST) begin
                        w_ev_valid  = 1'b1;
                        w_ev.kind   = bmc4b5b_pkg::KIND_CABLE_RST;
                        w_ev.done_res = 1'b1;
                    end
                end
                bmc4b5b_pkg::PH_DECODE: begin
                    if (!r_skip && w_sym_done) begin
                        if (!r_held[4]) begin
                            if (!w_code_data) begin
                                w_ev_valid      = 1'b1;
                                w_ev.kind       = (w_code == bmc4b5b_pkg::CODE_EOP) ?
                                                  bmc4b5b_pkg::KIND_END :
                                                  bmc4b5b_pkg::KIND_DEC_ERR;
                                w_ev.byte_total = r_cnt;
                                w_ev.done_res   = 1'b1;
                            end
                        end else if (!w_code_data) begin
                            w_ev_valid      = 1'b1;
                            w_ev.kind       = bmc4b5b_pkg::KIND_DEC_ERR;
                            w_ev.byte_total = r_cnt;
                            w_ev.done_res   = 1'b1;
                        end else begin
                            w_ev_valid      = 1'b1;
                            w_ev.kind       = bmc4b5b_pkg::KIND_DATA;
                            w_ev.data_byte  = {w_code[3:0], r_held[3:0]};
                            w_ev.byte_total = w_cnt_inc;
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        // unfinished status when a capture ends mid-packet or mid-hunt
        w_unf_valid = i_go && i_word.capture_end &&
                      (w_step_phase == bmc4b5b_pkg::PH_HUNT ||
                       w_step_phase == bmc4b5b_pkg::PH_DECODE);
        w_unf            = '0;
        w_unf.kind       = bmc4b5b_pkg::KIND_UNFINISHED;
        w_unf.byte_total = (w_step_phase == bmc4b5b_pkg::PH_DECODE) ? w_step_cnt : 8'd0;
        w_unf.done_res   = 1'b1;

        o_push.count = {1'b0, w_ev_valid} + {1'b0, w_unf_valid};
        o_push.res0  = w_ev_valid ? w_ev : w_unf;
        o_push.res1  = w_unf;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= bmc4b5b_pkg::PH_HUNT;
            r_ref_valid <= 1'b0;
            r_prev      <= 8'd0;
            r_window    <= 32'd0;
            r_skip      <= 1'b0;
            r_bitpos    <= 3'd0;
            r_sym       <= 5'd0;
            r_held      <= 5'd0;
            r_cnt       <= 8'd0;
        end else begin
            r_phase     <= n_phase;
            r_ref_valid <= n_ref_valid;
            r_prev      <= n_prev;
            r_window    <= n_window;
            r_skip      <= n_skip;
            r_bitpos    <= n_bitpos;
            r_sym       <= n_sym;
            r_held      <= n_held;
            r_cnt       <= n_cnt;
        end
    end

endmodule

// ===== rtl/core/bmc4b5b_res_fifo.sv =====
// result queue: takes up to two words a cycle, hands out one while i_stall is low
module bmc4b5b_res_fifo (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  bmc4b5b_pkg::t_res_push i_push,
    output logic                   o_room,
    output logic                   o_valid,
    output bmc4b5b_pkg::t_res_word o_word,
    input  logic                   i_stall
);

    bmc4b5b_pkg::t_res_word r_mem [bmc4b5b_pkg::RES_DEPTH];
    logic [bmc4b5b_pkg::RES_PTR_W-1:0] r_wr, n_wr;
    logic [bmc4b5b_pkg::RES_PTR_W-1:0] r_rd, n_rd;
    logic [bmc4b5b_pkg::RES_CNT_W-1:0] r_cnt, n_cnt;
    logic [bmc4b5b_pkg::RES_PTR_W-1:0] w_wr1;
    logic                              w_pop;

    // room for the two words one edge may give
    assign o_room  = (r_cnt <= bmc4b5b_pkg::RES_CNT_W'(bmc4b5b_pkg::RES_DEPTH - 2));
    assign o_valid = (r_cnt != '0);
    assign o_word  = r_mem[r_rd];
    assign w_pop   = o_valid && !i_stall;
    assign w_wr1   = r_wr + bmc4b5b_pkg::RES_PTR_W'(1);

    // pointer and fill count
    always_comb begin
        n_wr  = r_wr + bmc4b5b_pkg::RES_PTR_W'(i_push.count);
        n_rd  = w_pop ? r_rd + bmc4b5b_pkg::RES_PTR_W'(1) : r_rd;
        n_cnt = r_cnt + bmc4b5b_pkg::RES_CNT_W'(i_push.count)
                      - bmc4b5b_pkg::RES_CNT_W'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // word storage
    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr] <= i_push.res0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[w_wr1] <= i_push.res1;
        end
    end

endmodule

// ===== rtl/core/bmc_edge_timing_4b5b_receiver_unit.sv =====
// top level of the bmc edge timing 4b5b receiver
//
//  channel   dir   handshake            word
//  in        in    i_in_valid/o_in_stall   edge_time, capture_end
//  out       out   o_out_valid/i_out_stall kind, data_byte, byte_total, done_res
//  cfg       in    i_cfg_valid/o_cfg_ready short_gap_threshold
//
// one edge word a cycle while o_in_stall is low; an edge is decoded when it sits in the input
// register and the queue has room, and its result words are registered in the queue before they are valid
// an edge gives at most two result words, which go through a four-word queue;
// the input register holds while the queue has fewer than two free places
// synchronous active-low reset clears the decoder state, threshold to 60 and
// empties the queue
module bmc_edge_timing_4b5b_receiver_unit (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  bmc4b5b_pkg::t_edge_word i_in_word,
    output logic                    o_in_stall,
    output logic                    o_out_valid,
    output bmc4b5b_pkg::t_res_word  o_out_word,
    input  logic                    i_out_stall,
    input  logic                    i_cfg_valid,
    input  logic [7:0]              i_cfg_data,
    output logic                    o_cfg_ready
);

    logic                    r_in_valid, n_in_valid;
    bmc4b5b_pkg::t_edge_word r_in_word;
    logic                    w_room;
    logic                    w_go;
    logic                    w_accept;
    bmc4b5b_pkg::t_res_push  w_push;

    // input register handshake
    assign w_go        = r_in_valid && w_room;
    assign o_in_stall  = r_in_valid && !w_room;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_in_valid = r_in_valid;
        if (w_accept) begin
            n_in_valid = 1'b1;
        end else if (w_go) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_word <= i_in_word;
        end
    end

    // decoder
    bmc4b5b_decode u_decode (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_valid),
        .i_cfg_thr (i_cfg_data),
        .i_go      (w_go),
        .i_word    (r_in_word),
        .o_push    (w_push)
    );

    // result queue
    bmc4b5b_res_fifo u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_room  (w_room),
        .o_valid (o_out_valid),
        .o_word  (o_out_word),
        .i_stall (i_out_stall)
    );

endmodule

// ===== rtl/core/bmc4b5b_checker.sv =====
// port checker for the receiver top level and its bind
module bmc4b5b_checker (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   o_out_valid,
    input  bmc4b5b_pkg::t_res_word o_out_word,
    input  logic                   i_out_stall,
    input  logic                   o_in_stall
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("stalled result word changed");

    // reset leaves no result pending and no input stall
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid && !o_in_stall)
        else $error("pending activity after reset");

    // only data bytes are non-terminal
    a_done_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_word.kind == bmc4b5b_pkg::KIND_DATA) == !o_out_word.done_res))
        else $error("done flag does not match result kind");

    // status words carry no byte
    a_status_no_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.kind != bmc4b5b_pkg::KIND_DATA
        |-> o_out_word.data_byte == 8'd0)
        else $error("status word carries a data byte");

    // reset patterns report an empty byte count
    a_reset_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_word.kind == bmc4b5b_pkg::KIND_HARD_RST ||
                        o_out_word.kind == bmc4b5b_pkg::KIND_CABLE_RST)
        |-> o_out_word.byte_total == 8'd0)
        else $error("reset pattern with non-zero byte count");

endmodule

bind bmc_edge_timing_4b5b_receiver_unit bmc4b5b_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .o_out_word  (o_out_word),
    .i_out_stall (i_out_stall),
    .o_in_stall  (o_in_stall)
);

// ===== test/bmc_edge_timing_4b5b_receiver_checker.sv =====
// checker for the bmc edge timing 4b5b receiver: follows the channels, predicts result words
`timescale 1ns / 1ps
module bmc_edge_timing_4b5b_receiver_checker (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  bmc4b5b_pkg::t_edge_word i_in_word,
    input  logic                    i_in_stall,
    input  logic                    i_out_valid,
    input  bmc4b5b_pkg::t_res_word  i_out_word,
    input  logic                    i_out_stall,
    input  logic                    i_cfg_valid,
    input  logic [7:0]              i_cfg_data,
    input  logic                    i_cfg_ready,
    output int                      o_fail_count,
    output int                      o_pending
);

    // line patterns, oldest classification in bit 0
    localparam logic [31:0] LINE_SOP       = 32'hC7E3_C78D;
    localparam logic [31:0] LINE_HARD_RST  = 32'hF33F_3F3F;
    localparam logic [31:0] LINE_CABLE_RST = 32'h3C7F_E0FF;

    // symbol codes outside the nibble range
    localparam logic [7:0] SYM_ERR = 8'h90;
    localparam logic [7:0] SYM_EOP = 8'hF0;

    localparam logic [7:0] THRESHOLD_AT_RESET = 8'd60;
    localparam logic [7:0] COUNT_TOP          = 8'd255;

    // predicted decoder state
    bmc4b5b_pkg::t_phase phase_q;
    logic        ref_seen;
    logic [7:0]  last_stamp;
    logic [31:0] gap_window;
    logic        skip_half;
    logic [2:0]  bit_idx;
    logic [4:0]  line_bits;
    logic [4:0]  low_nibble;
    logic [7:0]  byte_count;
    logic [7:0]  threshold;

    bmc4b5b_pkg::t_res_word awaited_words [$];
    bmc4b5b_pkg::t_res_word want;
    int          fails = 0;

    // 4b5b symbol to nibble, first line bit in bit 0
    function automatic logic [7:0] nibble_of(input logic [4:0] line);
        case (line)
            5'b11110: return 8'h00;
            5'b01001: return 8'h01;
            5'b10100: return 8'h02;
            5'b10101: return 8'h03;
            5'b01010: return 8'h04;
            5'b01011: return 8'h05;
            5'b01110: return 8'h06;
            5'b01111: return 8'h07;
            5'b10010: return 8'h08;
            5'b10011: return 8'h09;
            5'b10110: return 8'h0A;
            5'b10111: return 8'h0B;
            5'b11010: return 8'h0C;
            5'b11011: return 8'h0D;
            5'b11100: return 8'h0E;
            5'b11101: return 8'h0F;
            5'b01101: return SYM_EOP;
            default:  return SYM_ERR;
        endcase
    endfunction

    task automatic clear_capture();
        phase_q    = bmc4b5b_pkg::PH_HUNT;
        ref_seen   = 1'b0;
        last_stamp = 8'd0;
        gap_window = 32'd0;
        skip_half  = 1'b0;
        bit_idx    = 3'd0;
        line_bits  = 5'd0;
        low_nibble = 5'd0;
        byte_count = 8'd0;
    endtask

    task automatic push_word(input bmc4b5b_pkg::t_kind kind, input logic [7:0] data,
                             input logic [7:0] total, input logic done);
        bmc4b5b_pkg::t_res_word r;
        r.kind       = kind;
        r.data_byte  = data;
        r.byte_total = total;
        r.done_res   = done;
        awaited_words.push_back(r);
    endtask

    // one accepted edge word through the predicted decoder
    task automatic decode_edge(input bmc4b5b_pkg::t_edge_word w);
        logic [7:0] gap;
        logic [7:0] code;
        logic       one;
        if (!ref_seen) begin
            ref_seen   = 1'b1;
            last_stamp = w.edge_time;
        end else if (phase_q == bmc4b5b_pkg::PH_HUNT) begin
            gap        = w.edge_time - last_stamp;
            last_stamp = w.edge_time;
            gap_window = gap_window >> 1;
            if (gap < threshold) gap_window[31] = 1'b1;
            if (gap_window == LINE_SOP) begin
                phase_q    = bmc4b5b_pkg::PH_DECODE;
                skip_half  = 1'b0;
                bit_idx    = 3'd0;
                line_bits  = 5'd0;
                low_nibble = 5'd0;
                byte_count = 8'd0;
            end else if (gap_window == LINE_HARD_RST) begin
                push_word(bmc4b5b_pkg::KIND_HARD_RST, 8'd0, 8'd0, 1'b1);
                phase_q = bmc4b5b_pkg::PH_DONE;
            end else if (gap_window == LINE_CABLE_RST) begin
                push_word(bmc4b5b_pkg::KIND_CABLE_RST, 8'd0, 8'd0, 1'b1);
                phase_q = bmc4b5b_pkg::PH_DONE;
            end
        end else if (phase_q == bmc4b5b_pkg::PH_DECODE) begin
            if (skip_half) begin
                // second half of a one carries no bit
                skip_half  = 1'b0;
                last_stamp = w.edge_time;
            end else begin
                gap        = w.edge_time - last_stamp;
                one        = gap < threshold;
                last_stamp = w.edge_time;
                skip_half  = one;
                if (one) line_bits[bit_idx] = 1'b1;
                bit_idx = bit_idx + 3'd1;
                if (bit_idx == 3'd5) begin
                    code      = nibble_of(line_bits);
                    bit_idx   = 3'd0;
                    line_bits = 5'd0;
                    if (!low_nibble[4]) begin
                        if (code > 8'd15) begin
                            push_word(code == SYM_EOP ? bmc4b5b_pkg::KIND_END :
                                      bmc4b5b_pkg::KIND_DEC_ERR, 8'd0,
                                      byte_count, 1'b1);
                            phase_q = bmc4b5b_pkg::PH_DONE;
                        end else begin
                            low_nibble = {1'b1, code[3:0]};
                        end
                    end else begin
                        // high nibble slot: any control code is an error
                        if (code > 8'd15) begin
                            push_word(bmc4b5b_pkg::KIND_DEC_ERR, 8'd0, byte_count, 1'b1);
                            phase_q = bmc4b5b_pkg::PH_DONE;
                        end else begin
                            if (byte_count != COUNT_TOP) byte_count = byte_count + 8'd1;
                            push_word(bmc4b5b_pkg::KIND_DATA,
                                      {code[3:0], low_nibble[3:0]}, byte_count, 1'b0);
                        end
                        low_nibble = 5'd0;
                    end
                end
            end
        end
        // capture end: unfinished status unless already terminated, then rearm
        if (w.capture_end) begin
            if (phase_q == bmc4b5b_pkg::PH_HUNT || phase_q == bmc4b5b_pkg::PH_DECODE) begin
                push_word(bmc4b5b_pkg::KIND_UNFINISHED, 8'd0,
                          phase_q == bmc4b5b_pkg::PH_DECODE ? byte_count : 8'd0, 1'b1);
            end
            clear_capture();
        end
    endtask

    // sample all channels at the rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            threshold = THRESHOLD_AT_RESET;
            clear_capture();
            awaited_words.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) threshold = i_cfg_data;
            if (i_out_valid && !i_out_stall) begin
                if (awaited_words.size() == 0) begin
                    fails = fails + 1;
                    // fields shown as kind/data/total/done
                    $display("%0t: unexpected word %0d/%02h/%0d/%0d",
                             $time, i_out_word.kind, i_out_word.data_byte,
                             i_out_word.byte_total, i_out_word.done_res);
                end else begin
                    want = awaited_words.pop_front();
                    if (i_out_word.kind !== want.kind
                            || i_out_word.data_byte !== want.data_byte
                            || i_out_word.byte_total !== want.byte_total
                            || i_out_word.done_res !== want.done_res) begin
                        fails = fails + 1;
                        // fields shown as kind/data/total/done
                        $display("%0t: expected %0d/%02h/%0d/%0d got %0d/%02h/%0d/%0d",
                                 $time, want.kind, want.data_byte, want.byte_total,
                                 want.done_res, i_out_word.kind, i_out_word.data_byte,
                                 i_out_word.byte_total, i_out_word.done_res);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) decode_edge(i_in_word);
        end
        o_fail_count <= fails;
        o_pending    <= awaited_words.size();
    end

endmodule

// ===== test/tb_bmc_edge_timing_4b5b_receiver_unit.sv =====
// testbench top of the bmc edge timing 4b5b receiver: edge stimulus, stalls and verdict
`timescale 1ns / 1ps
module tb_bmc_edge_timing_4b5b_receiver_unit;

    // capture shapes
    localparam int CAP_PACKET      = 0;
    localparam int CAP_HARD_RST    = 1;
    localparam int CAP_CABLE_RST   = 2;
    localparam int CAP_BAD_SYMBOL  = 3;
    localparam int CAP_EOP_HIGH    = 4;
    localparam int CAP_CUT_SHORT   = 5;
    localparam int CAP_NOISE       = 6;
    localparam int CAP_BROKEN_SOP  = 7;
    localparam int CAP_LONG_PACKET = 8;

    localparam logic [4:0] LINE_EOP = 5'b01101;

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    in_valid  = 1'b0;
    bmc4b5b_pkg::t_edge_word in_word   = '0;
    logic                    in_stall;
    logic                    out_valid;
    bmc4b5b_pkg::t_res_word  out_word;
    logic                    out_stall = 1'b0;
    logic                    cfg_valid = 1'b0;
    logic [7:0]              cfg_data  = 8'd0;
    logic                    cfg_ready;
    int                      fail_count;
    int                      pending;

    int          send_idle_pct = 36;
    int          recv_idle_pct = 74;
    logic [7:0]  threshold     = bmc4b5b_pkg::THRESH_RESET;
    logic [7:0]  cur_stamp     = 8'd0;
    int          edges_sent    = 0;
    int unsigned stall_clock   = 0;
    int          hold_left     = 0;

    always #2 clk = ~clk;

    bmc_edge_timing_4b5b_receiver_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_word   (in_word),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_word  (out_word),
        .i_out_stall (out_stall),
        .i_cfg_valid (cfg_valid),
        .i_cfg_data  (cfg_data),
        .o_cfg_ready (cfg_ready)
    );

    bmc_edge_timing_4b5b_receiver_checker u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_word    (in_word),
        .i_in_stall   (in_stall),
        .i_out_valid  (out_valid),
        .i_out_word   (out_word),
        .i_out_stall  (out_stall),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_data   (cfg_data),
        .i_cfg_ready  (cfg_ready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // receiver stalls, with a long hold-off now and then so the queue fills
    always @(negedge clk) begin : stall_drive
        logic stall_next;
        stall_clock = stall_clock + 1;
        if (stall_clock % 2500 == 600) hold_left = 200;
        if (hold_left > 0) begin
            hold_left  = hold_left - 1;
            stall_next = 1'b1;
        end else begin
            stall_next = ($urandom_range(99) < recv_idle_pct);
        end
        out_stall <= stall_next;
    end

    // nibble to 4b5b symbol, first line bit in bit 0
    function automatic logic [4:0] line_code(input logic [3:0] nib);
        case (nib)
            4'h0: return 5'b11110;
            4'h1: return 5'b01001;
            4'h2: return 5'b10100;
            4'h3: return 5'b10101;
            4'h4: return 5'b01010;
            4'h5: return 5'b01011;
            4'h6: return 5'b01110;
            4'h7: return 5'b01111;
            4'h8: return 5'b10010;
            4'h9: return 5'b10011;
            4'hA: return 5'b10110;
            4'hB: return 5'b10111;
            4'hC: return 5'b11010;
            4'hD: return 5'b11011;
            4'hE: return 5'b11100;
            default: return 5'b11101;
        endcase
    endfunction

    function automatic bit is_line_code(input logic [4:0] code);
        for (int i = 0; i < 16; i++) begin
            if (line_code(4'(i)) == code) return 1'b1;
        end
        return code == LINE_EOP;
    endfunction

    function automatic logic [7:0] short_gap();
        return 8'($urandom_range(int'(threshold) - 1, 0));
    endfunction

    function automatic logic [7:0] long_gap();
        return 8'($urandom_range(255, int'(threshold)));
    endfunction

    // offer one edge word, idling at random, and hold it until taken
    task automatic send_stamp(input logic [7:0] stamp, input logic last);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        in_word   <= '{edge_time: stamp, capture_end: last};
        cur_stamp  = stamp;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        edges_sent = edges_sent + 1;
    endtask

    task automatic edge_gap(input logic [7:0] gap, input logic last);
        send_stamp(cur_stamp + gap, last);
    endtask

    task automatic send_class(input logic is_short, input logic last);
        edge_gap(is_short ? short_gap() : long_gap(), last);
    endtask

    // bmc bit: a one is a short gap plus a second-half word of any timing
    task automatic send_bit(input logic b, input logic last);
        if (!b) begin
            edge_gap(long_gap(), last);
        end else begin
            edge_gap(short_gap(), 1'b0);
            edge_gap(8'($urandom_range(255, 0)), last);
        end
    endtask

    task automatic send_symbol(input logic [4:0] code, input logic last);
        for (int i = 0; i < 5; i++) send_bit(code[i], last && i == 4);
    endtask

    // words after a terminal result are ignored up to the capture end
    task automatic trailing_edges();
        int n;
        n = $urandom_range(5, 1);
        for (int i = 0; i < n; i++) edge_gap(8'($urandom_range(255, 0)), i == n - 1);
    endtask

    // one whole capture from the first word to capture end
    task automatic run_capture(input int sel);
        logic [31:0] pattern;
        logic [4:0]  bad;
        int          n;
        int          flip;
        bit          end_now;
        if (sel == CAP_NOISE) begin
            n = $urandom_range(30, 1);
            for (int i = 0; i < n; i++) edge_gap(8'($urandom_range(255, 0)), i == n - 1);
            return;
        end
        edge_gap(8'($urandom_range(255, 0)), 1'b0);
        repeat ($urandom_range(12, 0)) send_class($urandom_range(1, 0), 1'b0);
        case (sel)
            CAP_HARD_RST:  pattern = bmc4b5b_pkg::PAT_HARD_RESET;
            CAP_CABLE_RST: pattern = bmc4b5b_pkg::PAT_CABLE_RST;
            default:       pattern = bmc4b5b_pkg::PAT_SOP;
        endcase
        if (sel == CAP_BROKEN_SOP) begin
            flip = $urandom_range(31, 0);
            pattern[flip] = ~pattern[flip];
        end
        end_now = (sel == CAP_HARD_RST || sel == CAP_CABLE_RST || sel == CAP_BROKEN_SOP)
                  && $urandom_range(2, 0) == 0;
        for (int i = 0; i < 32; i++) send_class(pattern[i], end_now && i == 31);
        if (sel == CAP_HARD_RST || sel == CAP_CABLE_RST || sel == CAP_BROKEN_SOP) begin
            if (!end_now) trailing_edges();
            return;
        end
        // payload bytes, low nibble first
        n = (sel == CAP_LONG_PACKET) ? 257 : $urandom_range(6, 0);
        for (int i = 0; i < n; i++) begin
            if (sel == CAP_LONG_PACKET) begin
                send_symbol(line_code(4'd1 << $urandom_range(3, 0)), 1'b0);
                send_symbol(line_code(4'd1 << $urandom_range(3, 0)), 1'b0);
            end else begin
                send_symbol(line_code(4'($urandom_range(15, 0))), 1'b0);
                send_symbol(line_code(4'($urandom_range(15, 0))), 1'b0);
            end
        end
        end_now = $urandom_range(1, 0);
        case (sel)
            CAP_PACKET, CAP_LONG_PACKET: begin
                send_symbol(LINE_EOP, end_now);
            end
            CAP_BAD_SYMBOL: begin
                if ($urandom_range(1, 0)) send_symbol(line_code(4'($urandom_range(15, 0))), 1'b0);
                do bad = 5'($urandom_range(31, 0)); while (is_line_code(bad));
                send_symbol(bad, end_now);
            end
            CAP_EOP_HIGH: begin
                send_symbol(line_code(4'($urandom_range(15, 0))), 1'b0);
                send_symbol(LINE_EOP, end_now);
            end
            default: begin
                // cut off mid-stream, ending on a bit, a first half or a second half
                repeat ($urandom_range(9, 0)) send_bit($urandom_range(1, 0), 1'b0);
                case ($urandom_range(2, 0))
                    0:       send_bit(1'b0, 1'b1);
                    1:       edge_gap(short_gap(), 1'b1);
                    default: send_bit(1'b1, 1'b1);
                endcase
                end_now = 1'b1;
            end
        endcase
        if (!end_now) trailing_edges();
    endtask

    function automatic int pick_capture();
        int r;
        if (threshold == 8'd0) return CAP_NOISE;
        r = $urandom_range(99, 0);
        if (r < 30) return CAP_PACKET;
        if (r < 80) return $urandom_range(CAP_CUT_SHORT, CAP_PACKET);
        return (r < 90) ? CAP_NOISE : CAP_BROKEN_SOP;
    endfunction

    task automatic fill_edges(input int n);
        int target;
        target = edges_sent + n;
        while (edges_sent < target) run_capture(pick_capture());
    endtask

    // drop valid and wait for every expected word plus the pipeline
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [7:0] value);
        settle();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        threshold  = value;
    endtask

    // run limit
    initial begin
        #4_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // directed: wrap-around gaps, gap zero, gap at and just under the threshold
        send_stamp(8'd0, 1'b1);
        send_stamp(8'd255, 1'b0);
        send_stamp(8'd0, 1'b0);
        send_stamp(8'd255, 1'b0);
        send_stamp(8'd59, 1'b0);
        send_stamp(8'd118, 1'b0);
        send_stamp(8'd118, 1'b0);
        send_stamp(8'd0, 1'b1);
        for (int i = CAP_PACKET; i <= CAP_BROKEN_SOP; i++) run_capture(i);

        // sender idles lightly, receiver heavily
        fill_edges(40);
        write_threshold(8'd1);
        fill_edges(30);

        // the other way round
        send_idle_pct = 74;
        recv_idle_pct = 36;
        write_threshold(8'd255);
        fill_edges(40);
        write_threshold(8'd0);
        fill_edges(20);
        write_threshold(8'($urandom_range(254, 2)));
        fill_edges(30);

        // no idling
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_threshold(8'($urandom_range(254, 2)));
        fill_edges(40);
        write_threshold(bmc4b5b_pkg::THRESH_RESET);
        fill_edges(20);

        settle();
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/bmc4b5b_pkg.sv
rtl/core/bmc4b5b_decode.sv
rtl/core/bmc4b5b_res_fifo.sv
rtl/core/bmc_edge_timing_4b5b_receiver_unit.sv
rtl/core/bmc4b5b_checker.sv
test/bmc_edge_timing_4b5b_receiver_checker.sv
test/tb_bmc_edge_timing_4b5b_receiver_unit.sv
